// ----- design/graph_adjacency_store_assert.svh -----
// Assertion macros for the graph adjacency store.
`ifndef GRAPH_ADJACENCY_STORE_ASSERT_SVH
`define GRAPH_ADJACENCY_STORE_ASSERT_SVH
`ifndef SYNTHESIS
// Same-cycle implication: when ante holds, cons must hold.
`define GAS_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("graph_adjacency_store: same-cycle check failed");
// Next-cycle implication: when ante holds, cons must hold in the next cycle.
`define GAS_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("graph_adjacency_store: next-cycle check failed");
`else
`define GAS_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define GAS_ASSERT_NXT(label, clk, rst_n, ante, cons)
`endif
`endif

// ----- design/gas_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package gas_pkg;

    // Default sizing
    localparam int unsigned DEF_MAX_VERTICES = 16;
    localparam int unsigned DEF_ID_BITS      = 16;

    // Request codes
    typedef enum logic [1:0] {
        MODE_INS_VTX  = 2'd0,
        MODE_DEL_VTX  = 2'd1,
        MODE_INS_EDGE = 2'd2,
        MODE_DEL_EDGE = 2'd3
    } t_mode;

    // Result status codes
    typedef enum logic [1:0] {
        STS_DONE      = 2'd0,
        STS_EXISTS    = 2'd1,
        STS_NOT_FOUND = 2'd2,
        STS_FULL      = 2'd3
    } t_status;

    // Request payload
    typedef struct packed {
        t_mode       mode;
        logic [15:0] first_id;
        logic [15:0] second_id;
    } t_req;

    // Result payload
    typedef struct packed {
        t_status     status;
        logic [3:0]  first_slot;
        logic [3:0]  second_slot;
        logic [4:0]  vertex_total;
    } t_rsp;

    // Row operations of the shared shift/mask unit
    typedef enum logic [1:0] {
        ROW_DROP = 2'd0,
        ROW_SET  = 2'd1,
        ROW_CLR  = 2'd2
    } t_row_op;

    // Sequencer states
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SEARCH,
        ST_DECIDE,
        ST_ER_RD,
        ST_ER_WR,
        ST_ADJ_RD_A,
        ST_ADJ_CHK,
        ST_ADJ_RD_B,
        ST_ADJ_WR_B
    } t_state;

endpackage

`default_nettype wire

// ----- design/gas_ram.sv -----
`timescale 1ns / 1ps
`default_nettype none

module gas_ram #(
    parameter int unsigned WIDTH = 16,
    parameter int unsigned DEPTH = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // One write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

// ----- design/gas_row_unit.sv -----
`timescale 1ns / 1ps
`default_nettype none

module gas_row_unit #(
    parameter int unsigned ROW_W = 16,
    parameter int unsigned POS_W = 4
) (
    input  wire logic [ROW_W-1:0]   i_row,
    input  wire gas_pkg::t_row_op   i_op,
    input  wire logic [POS_W-1:0]   i_pos,
    output logic      [ROW_W-1:0]   o_row
);

    import gas_pkg::*;

    logic [ROW_W-1:0] w_bit;
    logic [ROW_W-1:0] w_low;

    // One-hot bit at pos and mask of the bits below it
    assign w_bit = ROW_W'(1) << i_pos;
    assign w_low = w_bit - 1'b1;

    // Drop removes column pos and moves higher columns down one place
    always_comb begin
        unique case (i_op)
            ROW_DROP: o_row = (i_row & w_low) | ((i_row >> 1) & ~w_low);
            ROW_SET:  o_row = i_row | w_bit;
            ROW_CLR:  o_row = i_row & ~w_bit;
            default:  o_row = i_row;
        endcase
    end

endmodule

`default_nettype wire

// ----- design/graph_adjacency_store.sv -----
// Undirected graph store: an ordered id table plus a symmetric bit adjacency
// matrix, both in single-read-port RAMs. A request is taken when start is high
// and busy is low; busy then stays high until the result has been produced, and
// the result is shown for exactly one cycle with o_done. The receiver cannot
// stall it, so capture o_rsp whenever o_done is high. The id search reads one
// slot per cycle; a vertex erase then compacts the rows with a read-modify-write
// per row (ST_ER_RD, then ST_ER_WR) through the adjacency RAM's one port. Its
// steps are set by that read port and by the shared row shift/mask unit.
`timescale 1ns / 1ps
`default_nettype none

`include "graph_adjacency_store_assert.svh"

module graph_adjacency_store #(
    parameter int unsigned MAX_VERTICES = gas_pkg::DEF_MAX_VERTICES,
    parameter int unsigned ID_BITS      = gas_pkg::DEF_ID_BITS
) (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           start,
    input  wire gas_pkg::t_req  i_req,
    output logic                busy,
    output logic                o_done,
    output gas_pkg::t_rsp       o_rsp
);

    import gas_pkg::*;

    localparam int unsigned SLOT_W = $clog2(MAX_VERTICES);
    localparam int unsigned CNT_W  = $clog2(MAX_VERTICES + 1);

    // Control registers
    t_state             r_state, n_state;
    logic [CNT_W-1:0]   r_count, n_count;
    logic               r_done,  n_done;

    // Working registers
    t_mode              r_mode,  n_mode;
    logic [ID_BITS-1:0] r_a_id,  n_a_id;
    logic [ID_BITS-1:0] r_b_id,  n_b_id;
    logic [CNT_W-1:0]   r_idx,   n_idx;
    logic               r_pend,  n_pend;
    logic [SLOT_W-1:0]  r_pidx,  n_pidx;
    logic               r_fa,    n_fa;
    logic               r_fb,    n_fb;
    logic [SLOT_W-1:0]  r_sa,    n_sa;
    logic [SLOT_W-1:0]  r_sb,    n_sb;
    t_rsp               r_rsp,   n_rsp;

    // RAM ports
    logic               w_id_we;
    logic               w_adj_we;
    logic [SLOT_W-1:0]  w_waddr;
    logic [SLOT_W-1:0]  w_raddr;
    logic [ID_BITS-1:0] w_id_wdata;
    logic [ID_BITS-1:0] w_id_rdata;
    logic [MAX_VERTICES-1:0] w_adj_wdata;
    logic [MAX_VERTICES-1:0] w_adj_rdata;

    // Row unit
    t_row_op            w_row_op;
    logic [SLOT_W-1:0]  w_row_pos;
    logic [MAX_VERTICES-1:0] w_row_out;

    // Sequencer helpers
    logic               w_edge_req;
    logic [SLOT_W-1:0]  w_idx_slot;
    logic [SLOT_W-1:0]  w_src;
    t_row_op            w_edge_op;
    logic               w_fin;
    t_status            w_status;
    logic [SLOT_W-1:0]  w_out_sa;
    logic [SLOT_W-1:0]  w_out_sb;

    gas_ram #(
        .WIDTH (ID_BITS),
        .DEPTH (MAX_VERTICES)
    ) u_id_ram (
        .i_clk   (i_clk),
        .i_we    (w_id_we),
        .i_waddr (w_waddr),
        .i_wdata (w_id_wdata),
        .i_raddr (w_raddr),
        .o_rdata (w_id_rdata)
    );

    gas_ram #(
        .WIDTH (MAX_VERTICES),
        .DEPTH (MAX_VERTICES)
    ) u_adj_ram (
        .i_clk   (i_clk),
        .i_we    (w_adj_we),
        .i_waddr (w_waddr),
        .i_wdata (w_adj_wdata),
        .i_raddr (w_raddr),
        .o_rdata (w_adj_rdata)
    );

    gas_row_unit #(
        .ROW_W (MAX_VERTICES),
        .POS_W (SLOT_W)
    ) u_row_unit (
        .i_row (w_adj_rdata),
        .i_op  (w_row_op),
        .i_pos (w_row_pos),
        .o_row (w_row_out)
    );

    assign w_edge_req = (r_mode == MODE_INS_EDGE) || (r_mode == MODE_DEL_EDGE);
    assign w_idx_slot = r_idx[SLOT_W-1:0];
    assign w_edge_op  = (r_mode == MODE_INS_EDGE) ? ROW_SET : ROW_CLR;
    // Source row during compaction skips the erased slot
    assign w_src      = (w_idx_slot < r_sa) ? w_idx_slot : w_idx_slot + 1'b1;

    // Next state and datapath control
    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_mode      = r_mode;
        n_a_id      = r_a_id;
        n_b_id      = r_b_id;
        n_idx       = r_idx;
        n_pend      = r_pend;
        n_pidx      = r_pidx;
        n_fa        = r_fa;
        n_fb        = r_fb;
        n_sa        = r_sa;
        n_sb        = r_sb;
        w_id_we     = 1'b0;
        w_adj_we    = 1'b0;
        w_waddr     = '0;
        w_raddr     = '0;
        w_id_wdata  = r_a_id;
        w_adj_wdata = '0;
        w_row_op    = w_edge_op;
        w_row_pos   = r_sb;
        w_fin       = 1'b0;
        w_status    = STS_DONE;
        w_out_sa    = r_sa;
        w_out_sb    = r_sb;

        unique case (r_state)
            ST_IDLE: begin
                if (start) begin
                    n_mode  = i_req.mode;
                    n_a_id  = ID_BITS'(i_req.first_id);
                    n_b_id  = ID_BITS'(i_req.second_id);
                    n_idx   = '0;
                    n_pend  = 1'b0;
                    n_fa    = 1'b0;
                    n_fb    = 1'b0;
                    n_sa    = '0;
                    n_sb    = '0;
                    n_state = ST_SEARCH;
                end
            end

            // Pipelined scan: issue slot idx, compare the slot read last cycle
            ST_SEARCH: begin
                if (r_pend) begin
                    if (!r_fa && (w_id_rdata == r_a_id)) begin
                        n_fa = 1'b1;
                        n_sa = r_pidx;
                    end
                    if (w_edge_req && !r_fb && (w_id_rdata == r_b_id)) begin
                        n_fb = 1'b1;
                        n_sb = r_pidx;
                    end
                end
                if (r_idx < r_count) begin
                    w_raddr = w_idx_slot;
                    n_pend  = 1'b1;
                    n_pidx  = w_idx_slot;
                    n_idx   = r_idx + 1'b1;
                end else begin
                    n_pend = 1'b0;
                    if (!r_pend) begin
                        n_state = ST_DECIDE;
                    end
                end
            end

            ST_DECIDE: begin
                unique case (r_mode)
                    MODE_INS_VTX: begin
                        if (r_fa) begin
                            w_fin    = 1'b1;
                            w_status = STS_EXISTS;
                        end else if (r_count == CNT_W'(MAX_VERTICES)) begin
                            w_fin    = 1'b1;
                            w_status = STS_FULL;
                            w_out_sa = '0;
                        end else begin
                            // New vertex goes to the first free slot, empty row
                            w_id_we     = 1'b1;
                            w_adj_we    = 1'b1;
                            w_waddr     = r_count[SLOT_W-1:0];
                            w_id_wdata  = r_a_id;
                            w_adj_wdata = '0;
                            n_count     = r_count + 1'b1;
                            w_fin       = 1'b1;
                            w_out_sa    = r_count[SLOT_W-1:0];
                        end
                    end
                    MODE_DEL_VTX: begin
                        if (!r_fa) begin
                            w_fin    = 1'b1;
                            w_status = STS_NOT_FOUND;
                        end else begin
                            n_idx   = '0;
                            n_state = ST_ER_RD;
                        end
                    end
                    default: begin
                        if (!(r_fa && r_fb)) begin
                            w_fin    = 1'b1;
                            w_status = STS_NOT_FOUND;
                        end else begin
                            n_state = ST_ADJ_RD_A;
                        end
                    end
                endcase
            end

            // Compaction: row idx takes row src with the erased column dropped
            ST_ER_RD: begin
                if ((r_idx + 1'b1) < r_count) begin
                    w_raddr = w_src;
                    n_state = ST_ER_WR;
                end else begin
                    n_count = r_count - 1'b1;
                    w_fin   = 1'b1;
                end
            end

            ST_ER_WR: begin
                w_row_op    = ROW_DROP;
                w_row_pos   = r_sa;
                w_id_we     = 1'b1;
                w_adj_we    = 1'b1;
                w_waddr     = w_idx_slot;
                w_id_wdata  = w_id_rdata;
                w_adj_wdata = w_row_out;
                n_idx       = r_idx + 1'b1;
                n_state     = ST_ER_RD;
            end

            ST_ADJ_RD_A: begin
                w_raddr = r_sa;
                n_state = ST_ADJ_CHK;
            end

            // Check the edge bit, then update row sa
            ST_ADJ_CHK: begin
                w_row_pos = r_sb;
                if ((r_mode == MODE_INS_EDGE) && w_adj_rdata[r_sb]) begin
                    w_fin    = 1'b1;
                    w_status = STS_EXISTS;
                end else if ((r_mode == MODE_DEL_EDGE) && !w_adj_rdata[r_sb]) begin
                    w_fin    = 1'b1;
                    w_status = STS_NOT_FOUND;
                end else begin
                    w_adj_we    = 1'b1;
                    w_waddr     = r_sa;
                    w_adj_wdata = w_row_out;
                    n_state     = ST_ADJ_RD_B;
                end
            end

            ST_ADJ_RD_B: begin
                w_raddr = r_sb;
                n_state = ST_ADJ_WR_B;
            end

            // Mirror bit in row sb
            ST_ADJ_WR_B: begin
                w_row_pos   = r_sa;
                w_adj_we    = 1'b1;
                w_waddr     = r_sb;
                w_adj_wdata = w_row_out;
                w_fin       = 1'b1;
            end

            default: begin
                n_state = ST_IDLE;
            end
        endcase

        // Result strobe
        n_done = w_fin;
        n_rsp  = r_rsp;
        if (w_fin) begin
            n_state            = ST_IDLE;
            n_rsp.status       = w_status;
            n_rsp.first_slot   = 4'(w_out_sa);
            n_rsp.second_slot  = 4'(w_out_sb);
            n_rsp.vertex_total = 5'(n_count);
        end
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_count <= '0;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_done  <= n_done;
        end
    end

    // Working registers and result payload
    always_ff @(posedge i_clk) begin
        r_mode <= n_mode;
        r_a_id <= n_a_id;
        r_b_id <= n_b_id;
        r_idx  <= n_idx;
        r_pend <= n_pend;
        r_pidx <= n_pidx;
        r_fa   <= n_fa;
        r_fb   <= n_fb;
        r_sa   <= n_sa;
        r_sb   <= n_sb;
        r_rsp  <= n_rsp;
    end

    assign busy   = (r_state != ST_IDLE);
    assign o_done = r_done;
    assign o_rsp  = r_rsp;

    // Checks
    `GAS_ASSERT_IMP(a_done_ends_busy, i_clk, i_rst_n, o_done, $past(busy))
    `GAS_ASSERT_NXT(a_accept_sets_busy, i_clk, i_rst_n, start && !busy, busy && !o_done)
    `GAS_ASSERT_IMP(a_count_in_range, i_clk, i_rst_n, 1'b1, r_count <= CNT_W'(MAX_VERTICES))
    `GAS_ASSERT_IMP(a_total_matches, i_clk, i_rst_n, o_done, o_rsp.vertex_total == 5'(r_count))

endmodule

`default_nettype wire

// ----- tb/sv/tb_graph_adjacency_store.sv -----
`timescale 1ns / 1ps

module tb_graph_adjacency_store;
    import gas_pkg::*;

    localparam int NV         = 16;
    localparam int POOL_SIZE  = 24;
    localparam int IDLE_LIMIT = 1000;
    localparam int TAIL_WAIT  = 64;

    logic i_clk;
    logic i_rst_n = 1'b0;
    logic start   = 1'b0;
    t_req i_req   = '0;
    logic busy;
    logic o_done;
    t_rsp o_rsp;

    graph_adjacency_store dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .start  (start),
        .i_req  (i_req),
        .busy   (busy),
        .o_done (o_done),
        .o_rsp  (o_rsp)
    );

    // Mirror of the graph: id table, vertex count, adjacency rows
    logic [15:0] tbl_ids [NV];
    logic [15:0] adj_bits[NV];
    int          tbl_count;

    t_rsp        outcome_q[$];
    int          errors;
    int          idle_cycles;
    int          burst_left;
    logic [15:0] id_pool[POOL_SIZE];

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    task automatic report_mismatch(input string msg);
        $display("MISMATCH at %0t: %s", $realtime, msg);
        errors++;
    endtask

    // Linear search of the occupied slots
    function automatic bit find_slot(input logic [15:0] id, output logic [3:0] slot);
        bit hit;
        hit  = 1'b0;
        slot = '0;
        for (int i = 0; i < NV; i++) begin
            if (!hit && i < tbl_count && tbl_ids[i] == id) begin
                hit  = 1'b1;
                slot = i[3:0];
            end
        end
        return hit;
    endfunction

    // Remove column p from a row, higher columns move down one place
    function automatic logic [15:0] drop_column(input logic [15:0] row, input int p);
        logic [15:0] lowpart;
        logic [15:0] highpart;
        lowpart  = row & ((16'd1 << p) - 16'd1);
        highpart = ((row >> p) >> 1) << p;
        return lowpart | highpart;
    endfunction

    // Apply one request to the mirror and return the answer the block owes
    function automatic t_rsp graph_outcome(input t_req rq);
        t_rsp       ans;
        logic [3:0] sa;
        logic [3:0] sb;
        bit         fa;
        bit         fb;
        bit         present;
        ans = '0;
        sa  = '0;
        sb  = '0;
        ans.status = STS_DONE;
        case (rq.mode)
            MODE_INS_VTX: begin
                if (find_slot(rq.first_id, sa)) begin
                    ans.status = STS_EXISTS;
                end else if (tbl_count >= NV) begin
                    ans.status = STS_FULL;
                    sa = '0;
                end else begin
                    sa = tbl_count[3:0];
                    tbl_ids[tbl_count]  = rq.first_id;
                    adj_bits[tbl_count] = '0;
                    for (int i = 0; i < NV; i++) adj_bits[i][tbl_count] = 1'b0;
                    tbl_count++;
                end
            end
            MODE_DEL_VTX: begin
                if (!find_slot(rq.first_id, sa)) begin
                    ans.status = STS_NOT_FOUND;
                end else begin
                    for (int i = int'(sa); i + 1 < tbl_count; i++) begin
                        tbl_ids[i]  = tbl_ids[i+1];
                        adj_bits[i] = adj_bits[i+1];
                    end
                    tbl_count--;
                    tbl_ids[tbl_count]  = '0;
                    adj_bits[tbl_count] = '0;
                    for (int i = 0; i < NV; i++) adj_bits[i] = drop_column(adj_bits[i], int'(sa));
                end
            end
            default: begin
                fa = find_slot(rq.first_id, sa);
                fb = find_slot(rq.second_id, sb);
                if (!fa || !fb) begin
                    ans.status = STS_NOT_FOUND;
                end else begin
                    present = adj_bits[sa][sb];
                    if (rq.mode == MODE_INS_EDGE) begin
                        if (present) begin
                            ans.status = STS_EXISTS;
                        end else begin
                            adj_bits[sa][sb] = 1'b1;
                            adj_bits[sb][sa] = 1'b1;
                        end
                    end else begin
                        if (!present) begin
                            ans.status = STS_NOT_FOUND;
                        end else begin
                            adj_bits[sa][sb] = 1'b0;
                            adj_bits[sb][sa] = 1'b0;
                        end
                    end
                end
            end
        endcase
        ans.first_slot   = sa;
        ans.second_slot  = sb;
        ans.vertex_total = tbl_count[4:0];
        return ans;
    endfunction

    // Send one request; the sender may idle between bursts of random length
    task automatic send_request(input t_mode m, input logic [15:0] a, input logic [15:0] b);
        t_req rq;
        int   gap;
        rq.mode      = m;
        rq.first_id  = a;
        rq.second_id = b;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 30);
            repeat (gap) @(posedge i_clk);
        end
        burst_left--;
        @(posedge i_clk);
        start <= 1'b1;
        i_req <= rq;
        do @(posedge i_clk); while (busy);
        outcome_q = {outcome_q, graph_outcome(rq)};
        start <= 1'b0;
    endtask

    // Hold off until every request has been answered
    task automatic wait_all_answered();
        while (outcome_q.size() != 0) @(posedge i_clk);
    endtask

    function automatic logic [15:0] pick_id(input int held_pct);
        int r;
        r = $urandom_range(0, 99);
        if (r < held_pct && tbl_count > 0) return tbl_ids[$urandom_range(0, tbl_count - 1)];
        if (r < held_pct + (100 - held_pct) * 3 / 4) return id_pool[$urandom_range(0, POOL_SIZE - 1)];
        return 16'($urandom);
    endfunction

    // Requests on an empty table find nothing
    task automatic test_empty_table();
        send_request(MODE_DEL_VTX, 16'hFFFF, 16'h0000);
        send_request(MODE_DEL_EDGE, 16'h0000, 16'hFFFF);
        send_request(MODE_INS_EDGE, 16'h1234, 16'h1234);
        wait_all_answered();
    endtask

    task automatic test_vertex_basic();
        send_request(MODE_INS_VTX, 16'h0000, 16'hFFFF);
        send_request(MODE_INS_VTX, 16'h0000, 16'h0000);
        send_request(MODE_INS_VTX, 16'hFFFF, 16'h0000);
        wait_all_answered();
    endtask

    // Present and absent edges, self-loops, missing endpoints
    task automatic test_edge_cases();
        send_request(MODE_INS_EDGE, 16'h0000, 16'hFFFF);
        send_request(MODE_INS_EDGE, 16'hFFFF, 16'h0000);
        send_request(MODE_INS_EDGE, 16'h0000, 16'h0000);
        send_request(MODE_DEL_EDGE, 16'h0000, 16'h0000);
        send_request(MODE_DEL_EDGE, 16'h0000, 16'h0000);
        send_request(MODE_INS_EDGE, 16'hFFFF, 16'h4321);
        send_request(MODE_DEL_EDGE, 16'h4321, 16'hFFFF);
        wait_all_answered();
    endtask

    task automatic test_table_full();
        for (int i = 0; i < NV - 2; i++) send_request(MODE_INS_VTX, 16'h0100 + 16'(i), 16'($urandom));
        send_request(MODE_INS_VTX, 16'h7777, 16'h0000);
        wait_all_answered();
    endtask

    // Erase in the middle, at the end and at the front, with edges across the gap
    task automatic test_vertex_erase();
        send_request(MODE_INS_EDGE, 16'h0100, 16'h010D);
        send_request(MODE_INS_EDGE, 16'hFFFF, 16'h0105);
        send_request(MODE_DEL_VTX, 16'hFFFF, 16'h0000);
        send_request(MODE_INS_EDGE, 16'h010D, 16'h0100);
        send_request(MODE_DEL_VTX, 16'h010D, 16'h0000);
        send_request(MODE_DEL_VTX, 16'h0000, 16'h0000);
        wait_all_answered();
    endtask

    task automatic random_round(input int n, input int ins_pct, input int era_pct);
        int          r;
        logic [15:0] a;
        logic [15:0] b;
        for (int k = 0; k < n; k++) begin
            r = $urandom_range(0, 99);
            if (r < ins_pct) begin
                send_request(MODE_INS_VTX, pick_id(20), 16'($urandom));
            end else if (r < ins_pct + era_pct) begin
                send_request(MODE_DEL_VTX, pick_id(70), 16'($urandom));
            end else begin
                a = pick_id(85);
                b = ($urandom_range(0, 9) == 0) ? a : pick_id(85);
                if ($urandom_range(0, 2) != 0) send_request(MODE_INS_EDGE, a, b);
                else send_request(MODE_DEL_EDGE, a, b);
            end
        end
    endtask

    // Table swings between empty and full under mixed traffic
    task automatic test_random_traffic();
        id_pool[0] = 16'h0000;
        id_pool[1] = 16'hFFFF;
        id_pool[2] = 16'h5555;
        id_pool[3] = 16'hAAAA;
        for (int i = 4; i < POOL_SIZE; i++) id_pool[i] = 16'($urandom);
        for (int pass = 0; pass < 3; pass++) begin
            random_round(140, 45, 10);
            random_round(120, 25, 25);
            random_round(110, 10, 40);
            if (pass == 1) wait_all_answered();
        end
        wait_all_answered();
    endtask

    // Result check against the oldest outstanding answer
    always @(posedge i_clk) begin
        t_rsp want;
        if (i_rst_n && o_done) begin
            if (outcome_q.size() == 0) begin
                report_mismatch($sformatf("result with no request pending: %h", o_rsp));
            end else begin
                want = outcome_q.pop_front();
                if (o_rsp.status != want.status)
                    report_mismatch($sformatf("status got %0d want %0d",
                                              o_rsp.status, want.status));
                if (o_rsp.first_slot != want.first_slot)
                    report_mismatch($sformatf("first_slot got %0d want %0d",
                                              o_rsp.first_slot, want.first_slot));
                if (o_rsp.second_slot != want.second_slot)
                    report_mismatch($sformatf("second_slot got %0d want %0d",
                                              o_rsp.second_slot, want.second_slot));
                if (o_rsp.vertex_total != want.vertex_total)
                    report_mismatch($sformatf("vertex_total got %0d want %0d",
                                              o_rsp.vertex_total, want.vertex_total));
            end
        end
    end

    // Watchdog: too long with no request taken and no result shown
    always @(posedge i_clk) begin
        if (!i_rst_n || (start && !busy) || o_done) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("== FAIL ==");
                $finish;
            end
        end
    end

    initial begin
        errors      = 0;
        idle_cycles = 0;
        burst_left  = 0;
        tbl_count   = 0;
        for (int i = 0; i < NV; i++) begin
            tbl_ids[i]  = '0;
            adj_bits[i] = '0;
        end
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_empty_table();
        test_vertex_basic();
        test_edge_cases();
        test_table_full();
        test_vertex_erase();
        test_random_traffic();

        wait_all_answered();
        repeat (TAIL_WAIT) @(posedge i_clk);
        if (outcome_q.size() != 0)
            report_mismatch($sformatf("%0d results never arrived", outcome_q.size()));
        if (errors == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
